// File: design/utls_pkg.sv
// ----------------------------------------------------------------------------
// utls_pkg - shared types and helpers for the lenient UTF-8 text scanner
// Character slot record, lead byte classification and the whitespace set.
// ----------------------------------------------------------------------------
package utls_pkg;

    localparam int CP_BITS = 21;
    localparam int SLOTS   = 4;
    localparam int PEND    = 3;

    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    // one character found during a byte's scan
    typedef struct packed {
        logic       valid;
        logic       blank;
        logic [2:0] width;
    } char_slot_t;

    // continuation bytes a lead byte asks for, 0 for a single byte
    function automatic logic [1:0] needed_tail(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if ((b & MASK_LEAD2) == CODE_LEAD2) n = 2'd1;
        else if ((b & MASK_LEAD3) == CODE_LEAD3) n = 2'd2;
        else if ((b & MASK_LEAD4) == CODE_LEAD4) n = 2'd3;
        return n;
    endfunction

    function automatic logic is_space(input logic [CP_BITS-1:0] cp);
        return (cp >= 21'h00009 && cp <= 21'h0000D) || cp == 21'h00020 ||
               cp == 21'h00085 || cp == 21'h000A0 || cp == 21'h01680 ||
               (cp >= 21'h02000 && cp <= 21'h0200A) || cp == 21'h02028 ||
               cp == 21'h02029 || cp == 21'h0202F || cp == 21'h0205F ||
               cp == 21'h03000;
    endfunction

endpackage

// File: design/utf8_lenient_text_scanner.sv
// ----------------------------------------------------------------------------
// utf8_lenient_text_scanner - lenient UTF-8 prefix length and visibility scan
// Counts the bytes of the first N characters of a string, N set by the
// character limit register, and flags any character outside the Unicode
// whitespace set.
//
//   channel   direction  payload
//   s_        in         tdata[7:0] text_byte, tlast is_last
//   m_        out        tdata[15:0] prefix_bytes, tuser[0] has_visible
//   cfg_wr_   in         character limit
//
// One byte is taken every cycle unless the skid register holds a result; the
// split of the pending lead sequence and up to four character updates settle
// combinationally before the counters. Each result is registered in the output
// register, or in the skid behind it; two result registers (output plus skid)
// let input run on while a result waits; input stalls only when both hold results.
// aresetn is synchronous; the character limit resets to 65535.
// ----------------------------------------------------------------------------
module utf8_lenient_text_scanner #(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] prefix_bytes
    output logic [0:0]  m_tuser,   // [0] has_visible
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [7:0]             pend_reg [utls_pkg::PEND];
    logic [7:0]             pend_next [utls_pkg::PEND];
    logic [1:0]             pend_count_reg;
    logic [1:0]             pend_count_next;
    logic [COUNT_BITS-1:0]  offset_reg;
    logic [COUNT_BITS-1:0]  offset_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic                   done_reg;
    logic                   done_next;
    logic                   seen_reg;
    logic                   seen_next;
    logic [15:0]            limit_reg;
    logic [COUNT_BITS:0]    sum;
    logic [CW-1:0]          off_wide;
    logic [15:0]            prefix_sat;

    utls_pkg::char_slot_t   slots [utls_pkg::SLOTS];

    logic                   s_fire;
    logic                   push;
    logic                   pop;
    logic                   out_v_reg;
    logic                   skid_v_reg;
    logic [15:0]            out_bytes_reg;
    logic                   out_vis_reg;
    logic [15:0]            skid_bytes_reg;
    logic                   skid_vis_reg;

    assign s_tready = !skid_v_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign push     = s_fire && s_tlast;
    assign pop      = out_v_reg && m_tready;

    assign m_tvalid   = out_v_reg;
    assign m_tdata    = out_bytes_reg;
    assign m_tuser[0] = out_vis_reg;

    utls_char_split u_split (
        .pend_bytes      (pend_reg),
        .pend_count      (pend_count_reg),
        .text_byte       (s_tdata),
        .is_last         (s_tlast),
        .slots           (slots),
        .pend_bytes_next (pend_next),
        .pend_count_next (pend_count_next)
    );

    // characters of this byte update the prefix counters in order
    always_comb begin
        offset_next = offset_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        seen_next   = seen_reg;
        sum         = '0;
        for (int i = 0; i < utls_pkg::SLOTS; i++) begin
            if (slots[i].valid) begin
                if (!slots[i].blank) seen_next = 1'b1;
                if (!done_next && (CW'(count_next) < CW'(limit_reg))) begin
                    sum = {1'b0, offset_next} + (COUNT_BITS+1)'(slots[i].width);
                    offset_next = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
                    if (count_next != COUNT_MAX) count_next = count_next + COUNT_BITS'(1);
                end else begin
                    done_next = 1'b1;
                end
            end
        end
        off_wide   = CW'(offset_next);
        prefix_sat = (off_wide > CW'(16'hFFFF)) ? 16'hFFFF : off_wide[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 16'hFFFF;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_count_reg <= 2'd0;
            offset_reg     <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            seen_reg       <= 1'b0;
        end else if (s_fire) begin
            if (s_tlast) begin
                pend_count_reg <= 2'd0;
                offset_reg     <= '0;
                count_reg      <= '0;
                done_reg       <= 1'b0;
                seen_reg       <= 1'b0;
            end else begin
                pend_count_reg <= pend_count_next;
                offset_reg     <= offset_next;
                count_reg      <= count_next;
                done_reg       <= done_next;
                seen_reg       <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pend_reg <= pend_next;
        end
    end

    // two-deep result queue: output register in front, skid behind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || pop) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= push;
            end else begin
                out_v_reg  <= push;
            end
        end else if (push) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || pop) begin
            if (skid_v_reg) begin
                out_bytes_reg <= skid_bytes_reg;
                out_vis_reg   <= skid_vis_reg;
                skid_bytes_reg <= prefix_sat;
                skid_vis_reg   <= seen_next;
            end else begin
                out_bytes_reg <= prefix_sat;
                out_vis_reg   <= seen_next;
            end
        end else if (push) begin
            skid_bytes_reg <= prefix_sat;
            skid_vis_reg   <= seen_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> pend_count_reg == 2'd0 && count_reg == '0 && !seen_reg)
        else $error("scan state not cleared after last byte");

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds a result while output register is empty");

    a_pend_is_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_count_reg != 2'd0 |->
            utls_pkg::needed_tail(pend_reg[0]) >= pend_count_reg)
        else $error("pending bytes do not start with an unfinished lead");
`endif

endmodule

// File: design/utls_char_split.sv
// ----------------------------------------------------------------------------
// utls_char_split - splits pending bytes plus one new byte into characters
// Combinational: gives up to four character slots in order and the pending
// lead sequence left over for the next byte.
// ----------------------------------------------------------------------------
module utls_char_split (
    input  logic [7:0]             pend_bytes [utls_pkg::PEND],
    input  logic [1:0]             pend_count,
    input  logic [7:0]             text_byte,
    input  logic                   is_last,
    output utls_pkg::char_slot_t   slots [utls_pkg::SLOTS],
    output logic [7:0]             pend_bytes_next [utls_pkg::PEND],
    output logic [1:0]             pend_count_next
);

    logic [7:0]                    seq_b [utls_pkg::SLOTS];
    logic [1:0]                    need_l;
    logic [1:0]                    need_b;
    logic                          cont_b;
    logic                          has_pend;
    logic                          complete;
    logic                          append;
    logic                          split;
    logic                          fresh;
    logic                          hold_b;
    logic [utls_pkg::CP_BITS-1:0]  cp;

    // pending bytes are always a lead plus valid continuations, so only the
    // new byte decides between completing, extending or breaking apart
    always_comb begin
        seq_b[0] = pend_bytes[0];
        seq_b[1] = (pend_count > 2'd1) ? pend_bytes[1] : text_byte;
        seq_b[2] = (pend_count > 2'd2) ? pend_bytes[2] : text_byte;
        seq_b[3] = text_byte;

        need_l   = utls_pkg::needed_tail(pend_bytes[0]);
        need_b   = utls_pkg::needed_tail(text_byte);
        cont_b   = (text_byte[7:6] == utls_pkg::CONT_TAG);
        has_pend = (pend_count != 2'd0);
        complete = has_pend && cont_b && (pend_count == need_l);
        append   = has_pend && cont_b && (pend_count != need_l) && !is_last;
        split    = has_pend && !complete && !append;
        fresh    = !has_pend || split;
        hold_b   = fresh && (need_b != 2'd0) && !is_last;

        case (need_l)
            2'd1:    cp = {10'd0, seq_b[0][4:0], seq_b[1][5:0]};
            2'd2:    cp = {5'd0, seq_b[0][3:0], seq_b[1][5:0], seq_b[2][5:0]};
            default: cp = {seq_b[0][2:0], seq_b[1][5:0], seq_b[2][5:0], seq_b[3][5:0]};
        endcase

        for (int i = 0; i < utls_pkg::PEND; i++) begin
            slots[i].valid = split && (2'(i) < pend_count);
            slots[i].blank = utls_pkg::is_space({13'd0, pend_bytes[i]});
            slots[i].width = 3'd1;
        end
        slots[3].valid = complete || (fresh && !hold_b);
        slots[3].blank = complete ? utls_pkg::is_space(cp)
                                  : utls_pkg::is_space({13'd0, text_byte});
        slots[3].width = complete ? ({1'b0, need_l} + 3'd1) : 3'd1;

        if (append)      pend_count_next = pend_count + 2'd1;
        else if (hold_b) pend_count_next = 2'd1;
        else             pend_count_next = 2'd0;

        for (int i = 0; i < utls_pkg::PEND; i++) begin
            pend_bytes_next[i] = pend_bytes[i];
            if (append && (2'(i) == pend_count)) pend_bytes_next[i] = text_byte;
            if (hold_b && (i == 0))              pend_bytes_next[i] = text_byte;
        end
    end

endmodule

// File: verif/tb_utf8_lenient_text_scanner.sv
// ----------------------------------------------------------------------------
// tb_utf8_lenient_text_scanner - self-checking bench for the UTF-8 scanner
// Sends byte strings (directed corner cases, then random well-formed and
// broken UTF-8) with bursty requests and a stalling receiver, predicts the
// prefix length and visibility flag per string and checks every result.
// ----------------------------------------------------------------------------
module tb_utf8_lenient_text_scanner;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 900;
    localparam logic [15:0] LIMIT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] prefix_bytes;
        logic        has_visible;
    } scan_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    utf8_lenient_text_scanner #(.COUNT_BITS(16)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // [7:0] text_byte
        .s_tlast     (s_tlast),     // is_last
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // [15:0] prefix_bytes
        .m_tuser     (m_tuser),     // [0] has_visible
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // scanner shadow state
    logic [15:0]  limit_q;
    logic [7:0]   held_bytes [0:2];
    int           held_count;
    logic [15:0]  prefix_len;
    logic [15:0]  chars_counted;
    logic         prefix_closed;
    logic         any_visible;
    scan_result_t expected_results [$];

    logic [7:0]   text_q [$];
    int           items_sent;
    int           burst_left;
    logic         no_gaps;
    int           errors;
    int           results_seen;
    int           stall_cycles;
    int           rx_mode;
    int           rx_left;

    function automatic logic is_blank(input logic [20:0] cp);
        if (cp >= 21'h09 && cp <= 21'h0D) return 1'b1;
        if (cp >= 21'h2000 && cp <= 21'h200A) return 1'b1;
        case (cp)
            21'h20, 21'h85, 21'hA0, 21'h1680, 21'h2028, 21'h2029,
            21'h202F, 21'h205F, 21'h3000: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int tail_len(input logic [7:0] b);
        casez (b)
            8'b110?????: return 1;
            8'b1110????: return 2;
            8'b11110???: return 3;
            default:     return 0;
        endcase
    endfunction

    function automatic void count_char(input logic [20:0] cp, input int width);
        logic [16:0] sum;
        if (!is_blank(cp)) any_visible = 1'b1;
        if (!prefix_closed && chars_counted < limit_q) begin
            sum = {1'b0, prefix_len} + 17'(width);
            prefix_len = sum[16] ? LIMIT_MAX : sum[15:0];
            if (chars_counted != LIMIT_MAX) chars_counted++;
        end else begin
            prefix_closed = 1'b1;
        end
    endfunction

    function automatic void clear_scan();
        held_count    = 0;
        prefix_len    = '0;
        chars_counted = '0;
        prefix_closed = 1'b0;
        any_visible   = 1'b0;
    endfunction

    // rescan held bytes plus the new one; a short lead waits unless the string ends
    function automatic void scan_byte(input logic [7:0] b, input logic last);
        logic [7:0]   window [0:3];
        logic [20:0]  cp;
        int           n, pos, need, avail, k, i;
        logic         ok, waiting;
        scan_result_t res;
        n = held_count;
        for (i = 0; i < n; i++) window[i] = held_bytes[i];
        window[n] = b;
        n++;
        pos = 0;
        waiting = 1'b0;
        while (pos < n && !waiting) begin
            need  = tail_len(window[pos]);
            avail = n - pos - 1;
            k     = (avail < need) ? avail : need;
            ok    = 1'b1;
            for (i = 1; i <= k; i++)
                if (window[pos + i][7:6] != utls_pkg::CONT_TAG) ok = 1'b0;
            if (need == 0 || !ok || (avail < need && last)) begin
                count_char({13'd0, window[pos]}, 1);
                pos++;
            end else if (avail >= need) begin
                case (need)
                    1: cp = {10'd0, window[pos][4:0], window[pos+1][5:0]};
                    2: cp = {5'd0, window[pos][3:0], window[pos+1][5:0],
                             window[pos+2][5:0]};
                    default: cp = {window[pos][2:0], window[pos+1][5:0],
                                   window[pos+2][5:0], window[pos+3][5:0]};
                endcase
                count_char(cp, need + 1);
                pos += need + 1;
            end else begin
                waiting = 1'b1;
            end
        end
        held_count = n - pos;
        for (i = 0; i < held_count; i++) held_bytes[i] = window[pos + i];
        if (last) begin
            res.prefix_bytes = prefix_len;
            res.has_visible  = any_visible;
            expected_results.push_back(res);
            clear_scan();
        end
    endfunction

    task automatic report_error(input string what, input int want, input int got);
        $display("ERROR result %0d: %s got %0d, want %0d", results_seen, what, got, want);
        errors++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            if (no_gaps) gap = 0;
            else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
            else gap = $urandom_range(0, 3);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        scan_byte(b, last);
        items_sent++;
    endtask

    // bytes go out from the most significant end of seq
    task automatic send_chunk(input logic [31:0] seq, input int len, input logic last);
        int i;
        for (i = len - 1; i >= 0; i--)
            send_byte(seq[8*i +: 8], last && i == 0);
    endtask

    task automatic idle_wait(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        idle_wait(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_q = value;
    endtask

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return LIMIT_MAX;
            2, 3:    return 16'($urandom_range(1, 12));
            4:       return 16'($urandom_range(13, 60));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_char(input logic [20:0] cp, input int width);
        case (width)
            1: text_q.push_back(cp[7:0]);
            2: begin
                text_q.push_back({3'b110, cp[10:6]});
                text_q.push_back({utls_pkg::CONT_TAG, cp[5:0]});
            end
            3: begin
                text_q.push_back({4'b1110, cp[15:12]});
                text_q.push_back({utls_pkg::CONT_TAG, cp[11:6]});
                text_q.push_back({utls_pkg::CONT_TAG, cp[5:0]});
            end
            default: begin
                text_q.push_back({5'b11110, cp[20:18]});
                text_q.push_back({utls_pkg::CONT_TAG, cp[17:12]});
                text_q.push_back({utls_pkg::CONT_TAG, cp[11:6]});
                text_q.push_back({utls_pkg::CONT_TAG, cp[5:0]});
            end
        endcase
    endtask

    function automatic logic [20:0] pick_blank();
        case ($urandom_range(0, 10))
            0, 1:    return 21'($urandom_range(9, 13));
            2:       return 21'h20;
            3:       return 21'h85;
            4:       return 21'hA0;
            5:       return 21'h1680;
            6:       return 21'($urandom_range(16'h2000, 16'h200A));
            7:       return $urandom_range(0, 1) ? 21'h2028 : 21'h2029;
            8:       return 21'h202F;
            9:       return 21'h205F;
            default: return 21'h3000;
        endcase
    endfunction

    task automatic push_random_char(input logic blank_only);
        logic [20:0] cp;
        int          kind, w, min_w;
        kind = blank_only ? 1 : $urandom_range(0, 11);
        cp   = 21'($urandom);
        case (kind)
            0: push_char(21'($urandom_range(8'h21, 8'h7E)), 1);
            1, 2: begin
                // blanks in their shortest form or overlong
                cp    = pick_blank();
                min_w = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : 3;
                push_char(cp, $urandom_range(min_w, 4));
            end
            3:    push_char(cp, 2);
            4:    push_char(cp, 3);
            5, 6: push_char(cp, 4);
            7:    text_q.push_back(8'($urandom));
            8, 11: begin
                // lead byte cut short of its continuation bytes
                w = $urandom_range(2, 4);
                push_char(cp, w);
                repeat ($urandom_range(1, w - 1)) void'(text_q.pop_back());
                if (kind == 11) text_q.push_back(8'($urandom_range(0, 8'h7F)));
            end
            9:       text_q.push_back({utls_pkg::CONT_TAG, 6'($urandom)});
            default: text_q.push_back(8'($urandom_range(0, 8'h7F)));
        endcase
    endtask

    // a limit write lands before byte split when split is in range
    task automatic send_text(input int split);
        int i, count;
        count = text_q.size();
        for (i = 0; i < count; i++) begin
            if (i == split) write_limit(pick_limit());
            send_byte(text_q[i], i == count - 1);
        end
        text_q.delete();
    endtask

    task automatic test_single_bytes();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h20, 1'b1);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h09, 1'b1);
    endtask

    task automatic test_multibyte();
        send_chunk(32'h0000C2A0, 2, 1'b1);   // no-break space
        send_chunk(32'h00E38080, 3, 1'b1);   // ideographic space
        send_chunk(32'hF09F9880, 4, 1'b1);
        send_chunk(32'h0000C080, 2, 1'b1);   // overlong NUL
        send_chunk(32'h00EDA080, 3, 1'b1);   // surrogate
        send_chunk(32'h0000E280, 2, 1'b1);   // lead cut off by end of string
        send_chunk(32'h0000C341, 2, 1'b1);   // lead followed by plain byte
        send_chunk(32'h0000F880, 2, 1'b1);
    endtask

    task automatic test_zero_limit();
        write_limit(16'd0);
        send_chunk(32'h00004120, 2, 1'b1);
        write_limit(LIMIT_MAX);
    endtask

    task automatic test_limit_change();
        // once a char misses the prefix, raising the limit does not reopen it
        write_limit(16'd1);
        send_chunk(32'h00006162, 2, 1'b0);
        write_limit(LIMIT_MAX);
        send_byte(8'h63, 1'b1);
        write_limit(16'd1);
        send_chunk(32'h00E38080, 3, 1'b0);
        write_limit(16'd2);
        send_chunk(32'h00004142, 2, 1'b1);
        write_limit(LIMIT_MAX);
    endtask

    task automatic test_long_string();
        int i;
        no_gaps = 1'b1;
        for (i = 0; i < 64; i++)
            send_chunk(32'hF0908080, 4, i == 63);
        no_gaps = 1'b0;
        idle_wait(0);
    endtask

    task automatic test_random();
        int   first_item, strings, nchars, split, i;
        logic blank_only;
        first_item = items_sent;
        strings    = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            if (strings % 12 == 0) write_limit(pick_limit());
            else if (strings % 25 == 7) idle_wait(0);
            blank_only = ($urandom_range(0, 4) == 0);
            nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                 : $urandom_range(1, 8);
            for (i = 0; i < nchars; i++) push_random_char(blank_only);
            no_gaps = ($urandom_range(0, 3) == 0);
            split   = -1;
            if (text_q.size() > 1 && $urandom_range(0, 14) == 0)
                split = $urandom_range(1, text_q.size() - 1);
            send_text(split);
            strings++;
        end
        no_gaps = 1'b0;
    endtask

    // receiver stall pattern: runs of always-ready, random, sparse and toggling
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(8, 64);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= rx_left[0];
        endcase
    end

    always @(posedge aclk) begin : check_result
        scan_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_error("unrequested result, prefix_bytes", 0, m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata != want.prefix_bytes)
                    report_error("prefix_bytes", want.prefix_bytes, m_tdata);
                if (m_tuser[0] != want.has_visible)
                    report_error("has_visible", want.has_visible, m_tuser[0]);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stall_cycles <= 0;
        else if (stall_cycles >= IDLE_LIMIT) begin
            $display("utf8_lenient_text_scanner: mismatch");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'h00;
        s_tlast     <= 1'b0;
        m_tready    <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 16'h0000;
        limit_q      = LIMIT_MAX;
        items_sent   = 0;
        burst_left   = 0;
        no_gaps      = 1'b0;
        errors       = 0;
        results_seen = 0;
        stall_cycles = 0;
        rx_mode      = 0;
        rx_left      = 0;
        clear_scan();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_single_bytes();
        test_multibyte();
        test_zero_limit();
        test_limit_change();
        test_long_string();
        test_random();

        idle_wait(8);
        if (errors == 0)
            $display("utf8_lenient_text_scanner: match");
        else
            $display("utf8_lenient_text_scanner: mismatch");
        $finish;
    end

endmodule
